// File: hdl/task_ready_and_wait_timer_table_defines.svh
// Assertion macros for the task ready and wait timer table.
// Depends on nothing; taken in by the top level only.
`ifndef TASK_READY_AND_WAIT_TIMER_TABLE_DEFINES_SVH
`define TASK_READY_AND_WAIT_TIMER_TABLE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TRWT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TRWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/trwt_pkg.sv
// Shared types and constants for the task ready and wait timer table.
// Used by trwt_ctrl, trwt_dp and the top level; depends on nothing.
package trwt_pkg;

    localparam int MASK_W  = 8;
    localparam int COUNT_W = 8;
    localparam int KIND_W  = 3;
    localparam int TASK_W  = 4;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXIT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TASK_W-1:0]  task_req;
        logic [COUNT_W-1:0] wait_ticks;
    } in_t;

    typedef struct packed {
        logic [MASK_W-1:0] ready_mask;
        logic [MASK_W-1:0] waiting_mask;
        logic [MASK_W-1:0] expired_mask;
    } out_t;

    typedef struct packed {
        logic load;
        logic apply;
    } ctrl_t;

endpackage

// File: hdl/trwt_ctrl.sv
// Controller for the task ready and wait timer table: sequences each beat
// through capture, apply and report. Depends on trwt_pkg.
module trwt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output trwt_pkg::ctrl_t ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
        done_next = (state_next == ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign ctl.load  = start && !busy_reg;
    assign ctl.apply = (state_reg == ST_EXEC);

endmodule

// File: hdl/trwt_dp.sv
// Datapath for the task ready and wait timer table: command register, one
// lane of flags and countdown per task, and the result register. Depends on trwt_pkg.
module trwt_dp
#(
    parameter int NUM_TASKS = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  trwt_pkg::ctrl_t ctl,
    input  trwt_pkg::in_t   cmd,
    output trwt_pkg::out_t  result
);

    localparam int MASK_W  = trwt_pkg::MASK_W;
    localparam int COUNT_W = trwt_pkg::COUNT_W;

    trwt_pkg::in_t  cmd_reg;
    trwt_pkg::out_t result_reg;
    trwt_pkg::out_t result_next;

    logic [NUM_TASKS-1:0] rdy_next;
    logic [NUM_TASKS-1:0] wt_next;
    logic [NUM_TASKS-1:0] exp_lane;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
        end
    end

    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_lane
        logic               hit;
        logic               rdy_reg;
        logic               rdy_nx;
        logic               wt_reg;
        logic               wt_nx;
        logic [COUNT_W-1:0] cnt_reg;
        logic [COUNT_W-1:0] cnt_nx;
        logic               exp_nx;

        assign hit = (32'(cmd_reg.task_req) == i + 1);

        always_comb
        begin
            rdy_nx = rdy_reg;
            wt_nx  = wt_reg;
            cnt_nx = cnt_reg;
            exp_nx = 1'b0;
            if (ctl.apply)
            begin
                unique case (cmd_reg.kind)
                    trwt_pkg::KIND_TICK:
                    begin
                        if (wt_reg)
                        begin
                            cnt_nx = cnt_reg - COUNT_W'(1);
                            if (cnt_reg == COUNT_W'(1))
                            begin
                                wt_nx  = 1'b0;
                                exp_nx = 1'b1;
                            end
                        end
                    end
                    trwt_pkg::KIND_REQUEST:
                    begin
                        if (hit)
                        begin
                            rdy_nx = 1'b1;
                        end
                    end
                    trwt_pkg::KIND_WAIT:
                    begin
                        if (hit)
                        begin
                            wt_nx  = 1'b1;
                            cnt_nx = cmd_reg.wait_ticks;
                        end
                    end
                    trwt_pkg::KIND_EXIT:
                    begin
                        if (hit)
                        begin
                            rdy_nx = 1'b0;
                            wt_nx  = 1'b0;
                            cnt_nx = '0;
                        end
                    end
                    trwt_pkg::KIND_CLEAR:
                    begin
                        rdy_nx = 1'b0;
                        wt_nx  = 1'b0;
                        cnt_nx = '0;
                    end
                    default:
                    begin
                        rdy_nx = rdy_reg;
                    end
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rdy_reg <= 1'b0;
                wt_reg  <= 1'b0;
                cnt_reg <= '0;
            end
            else
            begin
                rdy_reg <= rdy_nx;
                wt_reg  <= wt_nx;
                cnt_reg <= cnt_nx;
            end
        end

        assign rdy_next[i] = rdy_nx;
        assign wt_next[i]  = wt_nx;
        assign exp_lane[i] = exp_nx;
    end

    for (genvar b = 0; b < MASK_W; b++)
    begin : g_mask
        if (b < NUM_TASKS)
        begin : g_used
            assign result_next.ready_mask[b]   = rdy_next[b];
            assign result_next.waiting_mask[b] = wt_next[b];
            assign result_next.expired_mask[b] = exp_lane[b];
        end
        else
        begin : g_unused
            assign result_next.ready_mask[b]   = 1'b0;
            assign result_next.waiting_mask[b] = 1'b0;
            assign result_next.expired_mask[b] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.apply)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: hdl/task_ready_and_wait_timer_table.sv
// Top level of the task ready and wait timer table.
// Depends on trwt_pkg, trwt_ctrl, trwt_dp and the assertion macro header.
//
// Usage:
//   A command beat (kind, task_req, wait_ticks on cmd) is taken at a rising
//   edge where start is high and busy is low. busy rises the cycle after.
//   kind: tick, request, wait timer, exit, clear all; a request, wait or
//   exit for task 0 or above NUM_TASKS, or an unused kind, changes nothing.
//   One result beat per command: done is high for exactly one cycle and
//   result carries the ready, waiting and expired masks as they stand after
//   the command. Bit i-1 of each mask is task i, tasks 1 to 8 only.
//   Flow: the command is captured at the accepting edge, applied in the
//   controller's apply state, and done is high in its report state; busy
//   falls with done, so a new command is taken only after the report.
//   All task lanes update together in the apply cycle.
//   The receiver cannot stall: a result not taken in its done cycle is gone.
//   Reset clears every flag and count and returns the controller to idle.
`include "task_ready_and_wait_timer_table_defines.svh"

module task_ready_and_wait_timer_table
#(
    parameter int NUM_TASKS = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  trwt_pkg::in_t  cmd,
    output logic           done,
    output trwt_pkg::out_t result
);

    trwt_pkg::ctrl_t ctl;
    logic            expired_clash;

    trwt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    trwt_dp
    #(
        .NUM_TASKS (NUM_TASKS)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cmd    (cmd),
        .result (result)
    );

    assign expired_clash = |(result.expired_mask & result.waiting_mask);

    `TRWT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `TRWT_ASSERT_SAME(a_done_busy, done, busy, "done outside a busy window")
    `TRWT_ASSERT_NEXT(a_done_release, done, !busy && !done, "busy held after done")
    `TRWT_ASSERT_SAME(a_expired_left, done, !expired_clash, "expired task still waiting")

endmodule
